>>> hdl/mcos_pkg.sv
`default_nettype none

package mcos_pkg;

    localparam int DIM_W  = 15;
    localparam int LVL_W  = 4;
    localparam int CLS_W  = 2;
    localparam int BYTE_W = 31;

    localparam int DEF_MAX_DIM   = 16384;
    localparam int DEF_MAX_LEVEL = 15;

    localparam int DIM_LIMIT = 32767;
    localparam int LVL_LIMIT = 15;

    localparam logic [CLS_W-1:0] CLS_RGBA8 = 2'd0;
    localparam logic [CLS_W-1:0] CLS_BLK8  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_BLK16 = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] base_width;
        logic [DIM_W-1:0] base_height;
        logic [LVL_W-1:0] level;
        logic [CLS_W-1:0] block_class;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_offset;
        logic [BYTE_W-1:0] byte_size;
        logic [DIM_W-1:0]  level_width;
        logic [DIM_W-1:0]  level_height;
    } t_rsp;

    typedef struct packed {
        logic              valid;
        logic [LVL_W-1:0]  rem;
        logic [CLS_W-1:0]  cls;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [BYTE_W-1:0] offset;
    } t_stage;

    function automatic logic [BYTE_W:0] level_bytes(
        input logic [DIM_W-1:0] w,
        input logic [DIM_W-1:0] h,
        input logic [CLS_W-1:0] cls
    );
        logic [13:0]       bw;
        logic [13:0]       bh;
        logic [27:0]       nblk;
        logic [29:0]       npix;
        logic [BYTE_W:0]   p;
        bw   = 14'((16'(w) + 16'd3) >> 2);
        bh   = 14'((16'(h) + 16'd3) >> 2);
        nblk = 28'(bw) * 28'(bh);
        npix = 30'(w) * 30'(h);
        case (cls)
            CLS_BLK8:  p = {1'b0, nblk, 3'b000};
            CLS_BLK16: p = {nblk, 4'b0000};
            default:   p = {npix, 2'b00};
        endcase
        return p;
    endfunction

    function automatic logic [BYTE_W-1:0] sat_bytes(input logic [BYTE_W:0] b);
        return b[BYTE_W] ? {BYTE_W{1'b1}} : b[BYTE_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] sat_add(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W:0]   b
    );
        logic [BYTE_W+1:0] s;
        s = (BYTE_W+2)'(a) + (BYTE_W+2)'(b);
        return (s[BYTE_W+1:BYTE_W] != 2'b00) ? {BYTE_W{1'b1}} : s[BYTE_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] halve(input logic [DIM_W-1:0] d);
        return (d > DIM_W'(1)) ? (d >> 1) : DIM_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> hdl/mcos_cell.sv
`default_nettype none

module mcos_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  mcos_pkg::t_stage     i_stage,
    output mcos_pkg::t_stage     o_stage
);

    mcos_pkg::t_stage r_stage;
    mcos_pkg::t_stage n_stage;

    always_comb begin
        n_stage = i_stage;
        if (i_stage.rem != '0) begin
            n_stage.offset = mcos_pkg::sat_add(i_stage.offset,
                mcos_pkg::level_bytes(i_stage.w, i_stage.h, i_stage.cls));
            n_stage.w      = mcos_pkg::halve(i_stage.w);
            n_stage.h      = mcos_pkg::halve(i_stage.h);
            n_stage.rem    = i_stage.rem - mcos_pkg::LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

>>> hdl/mcos_size.sv
`default_nettype none

module mcos_size (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  mcos_pkg::t_stage     i_stage,
    output logic                 o_valid,
    output mcos_pkg::t_rsp       o_result
);

    logic              r_valid;
    mcos_pkg::t_rsp    r_result;
    mcos_pkg::t_rsp    n_result;

    always_comb begin
        n_result.byte_offset  = i_stage.offset;
        n_result.byte_size    = mcos_pkg::sat_bytes(
            mcos_pkg::level_bytes(i_stage.w, i_stage.h, i_stage.cls));
        n_result.level_width  = i_stage.w;
        n_result.level_height = i_stage.h;
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> hdl/mip_chain_offset_size.sv
// Mip chain offset and size.
// Command channel: a transaction is taken at each rising edge with start high
// and busy low; i_cmd carries base width, base height, level and block class.
// busy stays low, so a new transaction may be issued in every cycle.
// Result channel: o_valid marks o_result for exactly one cycle; it is not
// held, and the receiver has no means to stall it.
// Each command is registered in every cell in turn and then in the size
// register, which drives o_valid and o_result.
// One cell per mip level below the requested one adds that level's size to the
// running offset and halves the dimensions, later cells pass it on unchanged;
// the last stage forms the size of the requested level. Throughput is one
// transaction per cycle. Dimensions are clamped to 1..MAX_DIM (at most 32767)
// and the level to MAX_LEVEL (at most 15); byte counts saturate at 2^31-1.
// Block class 3 counts as uncompressed. Reset (synchronous, active low) drops
// every transaction in flight; no strobe is raised for them.
`default_nettype none

module mip_chain_offset_size #(
    parameter int MAX_DIM   = mcos_pkg::DEF_MAX_DIM,
    parameter int MAX_LEVEL = mcos_pkg::DEF_MAX_LEVEL
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  mcos_pkg::t_req     i_cmd,
    output logic               o_valid,
    output mcos_pkg::t_rsp     o_result
);

    localparam int DIM_CAP = (MAX_DIM > mcos_pkg::DIM_LIMIT) ? mcos_pkg::DIM_LIMIT : MAX_DIM;
    localparam int LVL_CAP = (MAX_LEVEL > mcos_pkg::LVL_LIMIT) ? mcos_pkg::LVL_LIMIT
                                                               : MAX_LEVEL;
    localparam logic [mcos_pkg::DIM_W-1:0] DIM_CAP_V = mcos_pkg::DIM_W'(DIM_CAP);
    localparam logic [mcos_pkg::LVL_W-1:0] LVL_CAP_V = mcos_pkg::LVL_W'(LVL_CAP);

    mcos_pkg::t_stage w_head;
    mcos_pkg::t_stage w_chain [0:MAX_LEVEL];

    function automatic logic [mcos_pkg::DIM_W-1:0] clamp_dim(
        input logic [mcos_pkg::DIM_W-1:0] d
    );
        if (d == '0) begin
            return mcos_pkg::DIM_W'(1);
        end else if (d > DIM_CAP_V) begin
            return DIM_CAP_V;
        end
        return d;
    endfunction

    assign busy = 1'b0;

    always_comb begin
        w_head.valid  = start & ~busy;
        w_head.rem    = (i_cmd.level > LVL_CAP_V) ? LVL_CAP_V : i_cmd.level;
        w_head.cls    = i_cmd.block_class;
        w_head.w      = clamp_dim(i_cmd.base_width);
        w_head.h      = clamp_dim(i_cmd.base_height);
        w_head.offset = '0;
    end

    assign w_chain[0] = w_head;

    for (genvar g = 0; g < MAX_LEVEL; g++) begin : g_cell
        mcos_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    mcos_size u_size (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stage  (w_chain[MAX_LEVEL]),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

>>> sim/mip_chain_offset_size_tb.sv
`timescale 1ns / 1ps

module mip_chain_offset_size_tb;

    localparam int PIPE_LAT = mcos_pkg::DEF_MAX_LEVEL + 1;
    localparam int N_RAND_PER_PHASE = 288;
    localparam logic [mcos_pkg::CLS_W-1:0] CLS_SPARE = 2'd3;
    localparam longint unsigned BYTE_CAP = 64'h7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    mcos_pkg::t_req i_cmd;
    logic o_valid;
    mcos_pkg::t_rsp o_result;

    mcos_pkg::t_rsp rsp_due [$];
    mcos_pkg::t_req dir_cmd [$];
    mcos_pkg::t_rsp dir_want [$];
    bit   dir_typed [$];
    int   n_err = 0;
    int   idle_pct;

    mip_chain_offset_size dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint unsigned clamp_base(input logic [mcos_pkg::DIM_W-1:0] d);
        if (d == '0) begin
            return 1;
        end
        if (d > mcos_pkg::DEF_MAX_DIM) begin
            return mcos_pkg::DEF_MAX_DIM;
        end
        return d;
    endfunction

    function automatic longint unsigned tile_bytes(input longint unsigned w,
                                                   input longint unsigned h,
                                                   input logic [mcos_pkg::CLS_W-1:0] cls);
        case (cls)
            mcos_pkg::CLS_BLK8:  return ((w + 3) / 4) * ((h + 3) / 4) * 8;
            mcos_pkg::CLS_BLK16: return ((w + 3) / 4) * ((h + 3) / 4) * 16;
            default:             return w * h * 4;
        endcase
    endfunction

    // walk the chain up to the requested level, summing the levels below it
    function automatic mcos_pkg::t_rsp mip_level_calc(input mcos_pkg::t_req r);
        longint unsigned w;
        longint unsigned h;
        longint unsigned off;
        longint unsigned sz;
        int              lvl;
        mcos_pkg::t_rsp  res;
        w   = clamp_base(r.base_width);
        h   = clamp_base(r.base_height);
        lvl = (r.level > mcos_pkg::DEF_MAX_LEVEL) ? mcos_pkg::DEF_MAX_LEVEL : int'(r.level);
        off = 0;
        for (int i = 0; i < lvl; i++) begin
            off = off + tile_bytes(w, h, r.block_class);
            if (off > BYTE_CAP) begin
                off = BYTE_CAP;
            end
            w = (w > 1) ? w / 2 : 1;
            h = (h > 1) ? h / 2 : 1;
        end
        sz = tile_bytes(w, h, r.block_class);
        if (sz > BYTE_CAP) begin
            sz = BYTE_CAP;
        end
        res.byte_offset  = mcos_pkg::BYTE_W'(off);
        res.byte_size    = mcos_pkg::BYTE_W'(sz);
        res.level_width  = (w > mcos_pkg::DIM_LIMIT) ? mcos_pkg::DIM_W'(mcos_pkg::DIM_LIMIT)
                                                     : mcos_pkg::DIM_W'(w);
        res.level_height = (h > mcos_pkg::DIM_LIMIT) ? mcos_pkg::DIM_W'(mcos_pkg::DIM_LIMIT)
                                                     : mcos_pkg::DIM_W'(h);
        return res;
    endfunction

    function automatic void add_row(input int w, input int h, input int lvl,
                                    input logic [mcos_pkg::CLS_W-1:0] cls,
                                    input bit typed,
                                    input longint unsigned off, input longint unsigned sz,
                                    input int lw, input int lh);
        mcos_pkg::t_req r;
        mcos_pkg::t_rsp x;
        r.base_width   = mcos_pkg::DIM_W'(w);
        r.base_height  = mcos_pkg::DIM_W'(h);
        r.level        = mcos_pkg::LVL_W'(lvl);
        r.block_class  = cls;
        x.byte_offset  = mcos_pkg::BYTE_W'(off);
        x.byte_size    = mcos_pkg::BYTE_W'(sz);
        x.level_width  = mcos_pkg::DIM_W'(lw);
        x.level_height = mcos_pkg::DIM_W'(lh);
        dir_cmd   = {dir_cmd, r};
        dir_want  = {dir_want, x};
        dir_typed = {dir_typed, typed};
    endfunction

    function automatic logic [mcos_pkg::DIM_W-1:0] rand_dim();
        case ($urandom_range(9, 0))
            0:       return mcos_pkg::DIM_W'($urandom_range(32767, 0));
            1:       return mcos_pkg::DIM_W'(1 << $urandom_range(14, 0));
            2:       return mcos_pkg::DIM_W'($urandom_range(8, 1));
            3: begin
                case ($urandom_range(3, 0))
                    0:       return '0;
                    1:       return mcos_pkg::DIM_W'(mcos_pkg::DEF_MAX_DIM);
                    2:       return mcos_pkg::DIM_W'(mcos_pkg::DEF_MAX_DIM + 1);
                    default: return '1;
                endcase
            end
            4, 5, 6: return mcos_pkg::DIM_W'($urandom_range(mcos_pkg::DEF_MAX_DIM, 1));
            default: return mcos_pkg::DIM_W'($urandom_range(256, 1));
        endcase
    endfunction

    function automatic mcos_pkg::t_req rand_req();
        mcos_pkg::t_req r;
        r.base_width  = rand_dim();
        r.base_height = rand_dim();
        r.level       = mcos_pkg::LVL_W'($urandom_range(15, 0));
        r.block_class = mcos_pkg::CLS_W'($urandom_range(3, 0));
        return r;
    endfunction

    // called at a rising edge; returns at the edge that takes the transaction
    task automatic issue(input mcos_pkg::t_req r, input mcos_pkg::t_rsp want);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= r;
        do begin
            @(posedge i_clk);
        end while (busy);
        rsp_due = {rsp_due, want};
    endtask

    task automatic drain();
        start <= 1'b0;
        while (rsp_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : rsp_chk
        mcos_pkg::t_rsp want;
        if (i_rst_n && o_valid) begin
            if (rsp_due.size() == 0) begin
                $error("unexpected result transaction: %h", o_result);
                n_err++;
            end else begin
                want = rsp_due.pop_front();
                if (o_result.byte_offset !== want.byte_offset) begin
                    $error("byte_offset: expected %0d, got %0d",
                           want.byte_offset, o_result.byte_offset);
                    n_err++;
                end
                if (o_result.byte_size !== want.byte_size) begin
                    $error("byte_size: expected %0d, got %0d",
                           want.byte_size, o_result.byte_size);
                    n_err++;
                end
                if (o_result.level_width !== want.level_width) begin
                    $error("level_width: expected %0d, got %0d",
                           want.level_width, o_result.level_width);
                    n_err++;
                end
                if (o_result.level_height !== want.level_height) begin
                    $error("level_height: expected %0d, got %0d",
                           want.level_height, o_result.level_height);
                    n_err++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        idle_pct = 0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;

        add_row(1, 1, 0, mcos_pkg::CLS_RGBA8, 1, 0, 4, 1, 1);
        add_row(1, 1, 0, mcos_pkg::CLS_BLK8, 1, 0, 8, 1, 1);
        add_row(1, 1, 0, mcos_pkg::CLS_BLK16, 1, 0, 16, 1, 1);
        add_row(1, 1, 0, CLS_SPARE, 1, 0, 4, 1, 1);
        add_row(0, 0, 0, mcos_pkg::CLS_RGBA8, 1, 0, 4, 1, 1);
        add_row(16384, 16384, 0, mcos_pkg::CLS_RGBA8, 1, 0, 1073741824, 16384, 16384);
        add_row(32767, 32767, 0, mcos_pkg::CLS_RGBA8, 1, 0, 1073741824, 16384, 16384);
        add_row(16385, 1, 0, mcos_pkg::CLS_RGBA8, 1, 0, 65536, 16384, 1);
        add_row(16384, 16384, 0, mcos_pkg::CLS_BLK8, 1, 0, 134217728, 16384, 16384);
        add_row(16384, 16384, 0, mcos_pkg::CLS_BLK16, 1, 0, 268435456, 16384, 16384);
        add_row(1, 1, 15, mcos_pkg::CLS_RGBA8, 1, 60, 4, 1, 1);
        add_row(1, 1, 15, mcos_pkg::CLS_BLK16, 1, 240, 16, 1, 1);
        add_row(1, 1, 15, CLS_SPARE, 1, 60, 4, 1, 1);
        add_row(16384, 16384, 15, mcos_pkg::CLS_RGBA8, 0, 0, 0, 0, 0);
        add_row(16384, 16384, 15, mcos_pkg::CLS_BLK16, 0, 0, 0, 0, 0);
        add_row(16384, 16384, 14, mcos_pkg::CLS_BLK8, 0, 0, 0, 0, 0);
        add_row(32767, 0, 15, CLS_SPARE, 0, 0, 0, 0, 0);
        add_row(5, 3, 1, mcos_pkg::CLS_BLK8, 0, 0, 0, 0, 0);
        add_row(4, 4, 1, mcos_pkg::CLS_RGBA8, 0, 0, 0, 0, 0);
        add_row(16384, 1, 15, mcos_pkg::CLS_RGBA8, 0, 0, 0, 0, 0);
        add_row(1, 16384, 15, mcos_pkg::CLS_BLK16, 0, 0, 0, 0, 0);
        add_row(21845, 10922, 10, mcos_pkg::CLS_BLK8, 0, 0, 0, 0, 0);
        add_row(10922, 21845, 5, mcos_pkg::CLS_BLK16, 0, 0, 0, 0, 0);
        add_row(3, 7, 2, mcos_pkg::CLS_RGBA8, 0, 0, 0, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_cmd[i]) begin
            issue(dir_cmd[i], dir_typed[i] ? dir_want[i] : mip_level_calc(dir_cmd[i]));
        end
        drain();

        // receiver cannot stall, so no phase stalls it; phases 0 and 2 run the sender flat out
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1:       idle_pct = 67;
                3:       idle_pct = 28;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < N_RAND_PER_PHASE; n++) begin
                mcos_pkg::t_req r;
                r = rand_req();
                issue(r, mip_level_calc(r));
            end
            drain();
        end

        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
